// File: sv/pwin_pkg.sv
// shared types, constants and helpers for the percentile winsorize core
package pwin_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_LEN     = 64;
	localparam int LEN_BITS    = 7;
	localparam int IDX_BITS    = 6;
	localparam int PCT_BITS    = 13;
	localparam int PCT_MAX     = 4999;
	localparam int PCT_FULL    = 10000;
	localparam int ACC_BITS    = 20;
	localparam int CFG_IDX_BITS = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [IDX_BITS-1:0]           idx_t;
	typedef logic [LEN_BITS-1:0]           len_t;
	typedef logic [PCT_BITS-1:0]           pct_t;
	typedef logic [ACC_BITS-1:0]           acc_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_VECTOR_LENGTH = 2'd0,
		REG_LOWER_PCT     = 2'd1,
		REG_UPPER_PCT     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic done;
		idx_t r_lo;
		idx_t r_hi;
	} rank_res_t;

	function automatic len_t eff_len(input len_t v);
		len_t r;
		r = v;
		if (v == '0) begin
			r = len_t'(1);
		end else if (v > len_t'(MAX_LEN)) begin
			r = len_t'(MAX_LEN);
		end
		return r;
	endfunction

	function automatic pct_t eff_pct(input pct_t p);
		return (p > pct_t'(PCT_MAX)) ? pct_t'(PCT_MAX) : p;
	endfunction

endpackage

// File: sv/pwin_ram.sv
// generic dual read port ram with registered reads
module pwin_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: sv/pwin_rank.sv
// iterative rank target computation by stepping multiples of the percent scale
module pwin_rank import pwin_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  idx_t      n_m1,
	input  pct_t      lo_pct,
	input  pct_t      up_pct,
	output rank_res_t res
);

	logic run_q;
	logic done_q;
	idx_t r_q;
	idx_t n_m1_q;
	acc_t acc_q;
	acc_t x_lo_q;
	acc_t x_hi_q;
	len_t cnt_lo_q;
	len_t cnt_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			done_q   <= 1'b0;
			r_q      <= '0;
			n_m1_q   <= '0;
			acc_q    <= '0;
			x_lo_q   <= '0;
			x_hi_q   <= '0;
			cnt_lo_q <= '0;
			cnt_hi_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q    <= 1'b1;
				r_q      <= '0;
				n_m1_q   <= n_m1;
				acc_q    <= '0;
				x_lo_q   <= acc_t'(acc_t'(lo_pct) * acc_t'(n_m1));
				x_hi_q   <= acc_t'((acc_t'(PCT_FULL) - acc_t'(up_pct)) * acc_t'(n_m1));
				cnt_lo_q <= '0;
				cnt_hi_q <= '0;
			end else if (run_q) begin
				// ceil counts steps strictly below, floor counts steps at or below
				if (acc_q < x_lo_q) begin
					cnt_lo_q <= cnt_lo_q + len_t'(1);
				end
				if (acc_q <= x_hi_q) begin
					cnt_hi_q <= cnt_hi_q + len_t'(1);
				end
				acc_q <= acc_q + acc_t'(PCT_FULL);
				r_q   <= r_q + idx_t'(1);
				if (r_q == n_m1_q) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		res.done = done_q;
		res.r_lo = cnt_lo_q[IDX_BITS-1:0];
		res.r_hi = IDX_BITS'(cnt_hi_q - len_t'(1));
	end

endmodule

// File: sv/percentile_winsorize_core.sv
// top level of the percentile winsorize core: load, rank search and clamp sequencer
// Samples are taken one per cycle while busy is low; a vector of L samples
// (L from vector_length) is buffered in a two read port sample memory. On the
// L-th sample busy rises. With L of 1 or a zero lower percentile the vector is
// replayed unchanged. Otherwise the rank targets are counted out first, then
// both order statistics are found by comparing every stored sample against
// every stored sample, itself included, one compare per cycle through the
// memory, and then the vector is replayed clamped to them. Results come one
// per cycle on result_valid, registered behind the registered memory reads,
// and cannot be held off; the last carries last_of_vector. Configuration is
// to be written only while idle, which the block itself does not enforce;
// writing vector_length drops a partly loaded vector.
module percentile_winsorize_core import pwin_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  sample_t                 sample_in,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [PCT_BITS-1:0]     cfg_wdata,
	output logic                    result_valid,
	output sample_t                 clipped_value,
	output logic                    last_of_vector
);

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_RANK = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t    state_q;
	len_t      vlen_q;
	pct_t      lo_pct_q;
	pct_t      up_pct_q;
	idx_t      fill_q;
	idx_t      i_q;
	idx_t      j_q;
	logic      drain_q;
	logic      pass_q;
	len_t      lt_q;
	len_t      le_q;
	sample_t   low_q;
	sample_t   high_q;
	logic      cmp_s1;
	logic      emit_s1;
	logic      last_s1;
	logic      jlast_s1;
	logic      result_valid_q;
	sample_t   clipped_q;
	logic      last_q;

	len_t      len_eff;
	idx_t      n_m1;
	pct_t      lo_eff;
	pct_t      up_eff;
	logic      accept;
	logic      load_done;
	logic      pass;
	logic      rank_start;
	rank_res_t rank_res;
	idx_t      raddr_b;
	logic [SAMPLE_BITS-1:0] rdata_a;
	logic [SAMPLE_BITS-1:0] rdata_b;
	sample_t   cand;
	sample_t   probe;
	logic      probe_lt;
	logic      probe_le;
	len_t      lt_new;
	len_t      le_new;
	logic      match_lo;
	logic      match_hi;
	sample_t   clamp_val;

	assign len_eff    = eff_len(vlen_q);
	assign n_m1       = IDX_BITS'(len_eff - len_t'(1));
	assign lo_eff     = eff_pct(lo_pct_q);
	assign up_eff     = eff_pct(up_pct_q);
	assign busy       = (state_q != ST_LOAD);
	assign accept     = start && !busy;
	assign load_done  = accept && (fill_q == n_m1);
	assign pass       = (len_eff == len_t'(1)) || (lo_eff == '0);
	assign rank_start = load_done && !pass;
	assign raddr_b    = i_q;

	pwin_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk    (clk),
		.we     (accept),
		.waddr  (fill_q),
		.wdata  (sample_in),
		.raddr_a(j_q),
		.rdata_a(rdata_a),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b)
	);

	pwin_rank u_rank (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rank_start),
		.n_m1  (n_m1),
		.lo_pct(lo_eff),
		.up_pct(up_eff),
		.res   (rank_res)
	);

	// shared compare: probe sample against candidate
	always_comb begin
		cand     = $signed(rdata_a);
		probe    = $signed(rdata_b);
		probe_lt = probe < cand;
		probe_le = probe <= cand;
		lt_new   = lt_q + len_t'(probe_lt);
		le_new   = le_q + len_t'(probe_le);
		match_lo = (lt_new <= len_t'(rank_res.r_lo)) && (len_t'(rank_res.r_lo) < le_new);
		match_hi = (lt_new <= len_t'(rank_res.r_hi)) && (len_t'(rank_res.r_hi) < le_new);
		clamp_val = probe;
		if (!pass_q) begin
			if (probe < low_q) begin
				clamp_val = low_q;
			end else if (probe > high_q) begin
				clamp_val = high_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q   <= len_t'(MAX_LEN);
			lo_pct_q <= '0;
			up_pct_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VECTOR_LENGTH: vlen_q   <= cfg_wdata[LEN_BITS-1:0];
				REG_LOWER_PCT:     lo_pct_q <= cfg_wdata;
				REG_UPPER_PCT:     up_pct_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			fill_q         <= '0;
			i_q            <= '0;
			j_q            <= '0;
			drain_q        <= 1'b0;
			pass_q         <= 1'b0;
			lt_q           <= '0;
			le_q           <= '0;
			low_q          <= '0;
			high_q         <= '0;
			cmp_s1         <= 1'b0;
			emit_s1        <= 1'b0;
			last_s1        <= 1'b0;
			jlast_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			clipped_q      <= '0;
			last_q         <= 1'b0;
		end else begin
			cmp_s1   <= (state_q == ST_SEL) && !drain_q;
			emit_s1  <= (state_q == ST_EMIT);
			last_s1  <= (i_q == n_m1);
			jlast_s1 <= (j_q == n_m1);

			case (state_q)
				ST_LOAD: begin
					if (cfg_we && (cfg_index == REG_VECTOR_LENGTH)) begin
						fill_q <= '0;
					end else if (load_done) begin
						fill_q  <= '0;
						pass_q  <= pass;
						i_q     <= '0;
						j_q     <= '0;
						drain_q <= 1'b0;
						state_q <= pass ? ST_EMIT : ST_RANK;
					end else if (accept) begin
						fill_q <= fill_q + idx_t'(1);
					end
				end
				ST_RANK: begin
					if (rank_res.done) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					if (!drain_q) begin
						if (i_q == n_m1) begin
							i_q <= '0;
							if (j_q == n_m1) begin
								drain_q <= 1'b1;
							end else begin
								j_q <= j_q + idx_t'(1);
							end
						end else begin
							i_q <= i_q + idx_t'(1);
						end
					end
					if (cmp_s1 && last_s1 && jlast_s1) begin
						drain_q <= 1'b0;
						i_q     <= '0;
						j_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (i_q == n_m1) begin
						i_q     <= '0;
						state_q <= ST_LOAD;
					end else begin
						i_q <= i_q + idx_t'(1);
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			// candidate rank counting
			if (cmp_s1) begin
				if (last_s1) begin
					lt_q <= '0;
					le_q <= '0;
					if (match_lo) begin
						low_q <= cand;
					end
					if (match_hi) begin
						high_q <= cand;
					end
				end else begin
					lt_q <= lt_new;
					le_q <= le_new;
				end
			end

			result_valid_q <= emit_s1;
			clipped_q      <= clamp_val;
			last_q         <= emit_s1 && last_s1;
		end
	end

	assign result_valid   = result_valid_q;
	assign clipped_value  = clipped_q;
	assign last_of_vector = last_q;

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_vector |=> !result_valid)
		else $error("result strobe right after end of vector");

	a_done_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		rank_res.done |-> state_q == ST_RANK)
		else $error("rank done outside rank phase");

	a_sel_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RANK) && rank_res.done |=> (state_q == ST_SEL) && (i_q == '0) && (j_q == '0))
		else $error("search did not start at first pair");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL |-> (rank_res.r_lo <= n_m1) && (rank_res.r_hi <= n_m1))
		else $error("rank target beyond vector");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(fill_q) || (fill_q == '0))
		else $error("fill count moved while busy");

endmodule

// File: test/percentile_winsorize_core_test.sv
// testbench for percentile_winsorize_core: directed and random vectors checked against a rank-clamp predictor
module percentile_winsorize_core_test;
	import pwin_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	class clamp_tracker;
		bit [LEN_BITS-1:0] len_reg;
		bit [PCT_BITS-1:0] lo_reg;
		bit [PCT_BITS-1:0] up_reg;
		sample_t           store[MAX_LEN];
		int                fill;
		sample_t           low_b;
		sample_t           high_b;
		sample_t           want_value[$];
		bit                want_last[$];
		int                errors;
		int                vectors;
		int                clamped_vectors;
		int                checked;

		function new();
			len_reg = 7'd64;
			lo_reg = '0;
			up_reg = '0;
			fill = 0;
			low_b = '0;
			high_b = '0;
			errors = 0;
			vectors = 0;
			clamped_vectors = 0;
			checked = 0;
		endfunction

		function int active_len();
			if (len_reg == 0) return 1;
			if (len_reg > MAX_LEN) return MAX_LEN;
			return int'(len_reg);
		endfunction

		function int limit_pct(bit [PCT_BITS-1:0] p);
			return (p > PCT_MAX) ? PCT_MAX : int'(p);
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [PCT_BITS-1:0] val);
			case (idx)
				REG_VECTOR_LENGTH: begin
					len_reg = val[LEN_BITS-1:0];
					fill = 0;
				end
				REG_LOWER_PCT: lo_reg = val;
				REG_UPPER_PCT: up_reg = val;
				default: ;
			endcase
		endfunction

		// value of ascending rank k among the first n held samples
		function sample_t order_stat(int n, int k);
			int lt;
			int le;
			for (int j = 0; j < n; j++) begin
				lt = 0;
				le = 0;
				for (int i = 0; i < n; i++) begin
					if (store[i] < store[j]) lt++;
					if (store[i] <= store[j]) le++;
				end
				if (lt <= k && k < le) return store[j];
			end
			return store[0];
		endfunction

		function void take_sample(sample_t s);
			int      n;
			int      lo_p;
			int      up_p;
			int      r_lo;
			int      r_hi;
			bit      pass;
			sample_t v;
			n = active_len();
			if (fill >= n) fill = 0;
			store[fill] = s;
			fill++;
			if (fill < n) return;
			lo_p = limit_pct(lo_reg);
			up_p = limit_pct(up_reg);
			pass = (n == 1) || (lo_p == 0);
			if (!pass) begin
				r_lo = (lo_p * (n - 1) + PCT_FULL - 1) / PCT_FULL;
				r_hi = ((PCT_FULL - up_p) * (n - 1)) / PCT_FULL;
				if (r_lo > n - 1) r_lo = n - 1;
				if (r_hi > n - 1) r_hi = n - 1;
				low_b = order_stat(n, r_lo);
				high_b = order_stat(n, r_hi);
				clamped_vectors++;
			end
			for (int i = 0; i < n; i++) begin
				v = store[i];
				if (!pass) begin
					if (v < low_b) v = low_b;
					else if (v > high_b) v = high_b;
				end
				want_value.push_back(v);
				want_last.push_back(i == n - 1);
			end
			fill = 0;
			vectors++;
		endfunction

		function void match_output(sample_t value, logic last);
			sample_t ev;
			bit      el;
			if (want_value.size() == 0) begin
				$display("%0t: result %0d last %0b with no transaction outstanding",
					$time, value, last);
				errors++;
				return;
			end
			ev = want_value.pop_front();
			el = want_last.pop_front();
			checked++;
			if (value !== ev) begin
				$display("%0t: clipped_value expected %0d got %0d", $time, ev, value);
				errors++;
			end
			if (last !== el) begin
				$display("%0t: last_of_vector expected %0b got %0b", $time, el, last);
				errors++;
			end
		endfunction

		function int pending();
			return want_value.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	sample_t                 sample_in;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [PCT_BITS-1:0]     cfg_wdata;
	logic                    result_valid;
	sample_t                 clipped_value;
	logic                    last_of_vector;

	clamp_tracker sb;
	int           n_items;
	int           n_writes;
	int           burst_left;
	int           gap_max;

	percentile_winsorize_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.sample_in     (sample_in),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.result_valid  (result_valid),
		.clipped_value (clipped_value),
		.last_of_vector(last_of_vector)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 1000000);
		$display("timeout waiting for results");
		$display("percentile_winsorize_core_test: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy) sb.take_sample(sample_in);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.match_output(clipped_value, last_of_vector);
	end

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [PCT_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		n_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(input sample_t v);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		sample_in <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
	endtask

	// stop sending and let every outstanding vector come out
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0 || busy) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic sample_t pick_sample(input int mode);
		int m;
		m = (mode == 3) ? $urandom_range(0, 2) : mode;
		case (m)
			0: return sample_t'($urandom_range(0, 65535));
			1: return sample_t'(int'($urandom_range(0, 4)) - 2);
			default: begin
				case ($urandom_range(0, 3))
					0: return sample_t'(-32768);
					1: return sample_t'(32767);
					2: return sample_t'(0);
					default: return sample_t'(-1);
				endcase
			end
		endcase
	endfunction

	function automatic logic [PCT_BITS-1:0] pick_pct(input bit lower);
		case ($urandom_range(0, 9))
			0: return lower ? 13'd0 : 13'd4999;
			1: return 13'd4999;
			2: return 13'($urandom_range(5000, 8191));
			3: return 13'd8191;
			4: return lower ? 13'd1 : 13'd0;
			default: return 13'($urandom_range(1, 4999));
		endcase
	endfunction

	function automatic logic [PCT_BITS-1:0] pick_len();
		case ($urandom_range(0, 15))
			0: return 13'd64;
			1: return 13'd0;
			2: return 13'($urandom_range(65, 127));
			3: return 13'd1;
			4: return 13'h1f80 | 13'($urandom_range(2, 8));
			5, 6: return 13'($urandom_range(17, 40));
			default: return 13'($urandom_range(2, 16));
		endcase
	endfunction

	initial begin
		int directed;
		int n;
		int nvec;
		int mode;
		sb = new();
		n_items = 0;
		n_writes = 0;
		burst_left = 0;
		gap_max = 0;
		arst_n <= 1'b0;
		start <= 1'b0;
		sample_in <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// single-sample vectors pass through
		write_reg(REG_VECTOR_LENGTH, 13'd1);
		send_sample(sample_t'(32767));
		send_sample(sample_t'(-32768));
		send_sample(sample_t'(0));
		send_sample(sample_t'(-1));
		drain();
		// out-of-range percent and zero length
		write_reg(REG_LOWER_PCT, 13'd8191);
		write_reg(REG_UPPER_PCT, 13'd8191);
		write_reg(REG_VECTOR_LENGTH, 13'd0);
		send_sample(sample_t'(16'h1234));
		drain();
		// crossed ranks
		write_reg(REG_VECTOR_LENGTH, 13'd4);
		send_sample(sample_t'(-32768));
		send_sample(sample_t'(32767));
		send_sample(sample_t'(21845));
		send_sample(sample_t'(-21846));
		drain();
		// zero lower percent passes through
		write_reg(REG_LOWER_PCT, 13'd0);
		write_reg(REG_VECTOR_LENGTH, 13'd3);
		send_sample(sample_t'(5));
		send_sample(sample_t'(-5));
		send_sample(sample_t'(7));
		drain();
		// partial vector dropped by a length write, then ties
		write_reg(REG_LOWER_PCT, 13'd2500);
		write_reg(REG_UPPER_PCT, 13'd2500);
		write_reg(REG_VECTOR_LENGTH, 13'd5);
		send_sample(sample_t'(-300));
		send_sample(sample_t'(300));
		drain();
		write_reg(REG_VECTOR_LENGTH, 13'd5);
		send_sample(sample_t'(3));
		send_sample(sample_t'(3));
		send_sample(sample_t'(-1));
		send_sample(sample_t'(3));
		send_sample(sample_t'(100));
		drain();
		// percent rewritten mid vector applies at completion
		send_sample(sample_t'(-9));
		send_sample(sample_t'(40));
		drain();
		write_reg(REG_UNUSED, 13'd8191);
		write_reg(REG_UPPER_PCT, 13'd0);
		send_sample(sample_t'(12));
		send_sample(sample_t'(-20000));
		send_sample(sample_t'(20000));
		drain();
		directed = n_items;

		while (n_items < directed + 470) begin
			drain();
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 3) != 0) write_reg(REG_VECTOR_LENGTH, pick_len());
			write_reg(REG_LOWER_PCT, pick_pct(1'b1));
			write_reg(REG_UPPER_PCT, pick_pct(1'b0));
			if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 13'($urandom));
			n = sb.active_len();
			nvec = (n > 32) ? 1 : $urandom_range(1, 3);
			mode = $urandom_range(0, 3);
			repeat (nvec * n) send_sample(pick_sample(mode));
			if (n > 1 && $urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, n - 1)) send_sample(pick_sample(mode));
		end
		drain();

		$display("sent %0d samples and %0d register writes; %0d vectors out, %0d clamped",
			n_items, n_writes, sb.vectors, sb.clamped_vectors);
		$display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("percentile_winsorize_core_test: clean");
		end else begin
			$display("percentile_winsorize_core_test: errors");
		end
		$finish;
	end

endmodule
